FILE: rtl/btil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btil_pkg
// Shared types and constants for the bitmask to index list converter.
// ----------------------------------------------------------------------------
package btil_pkg;

  localparam int WORD_BITS   = 64;
  localparam int VBITS_W     = 7;
  localparam int COUNT_W     = 32;
  localparam int OUT_ROW_W   = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_SCAN
  } scan_state_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row_index;
    logic                 found;
    logic [COUNT_W-1:0]   selected_so_far;
    logic                 last_of_item;
  } btil_result_t;

endpackage

FILE: rtl/bitmask_to_index_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmask_to_index_list_top
// Turns a stream of 64-bit selection mask words into the ascending list of
// selected row indices with a running selected count.
// ----------------------------------------------------------------------------
// Each input item is one mask word; bit b stands for row base + b, and only
// the low valid_bits bits count. The word is scanned one bit per clock by a
// shift register, so after it is accepted an item occupies the block until
// its scan ends: the scan stops right after the highest set bit, a word with
// no set bit emits a single result with found clear, and each set bit holds
// the scan until the output register can take its result. A new word is
// taken only in the idle state that follows, so a word is never accepted
// while the last one is still in the scan. Row indices wrap at ROW_INDEX_BITS
// bits, the count saturates at all ones, and both the row base and the count
// return to zero after a word marked with tlast.
// ----------------------------------------------------------------------------
module bitmask_to_index_list_top #(
  parameter int ROW_INDEX_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // mask_word [63:0], valid_bits [70:64], zero pad [71]
  input  logic [btil_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,   // end_of_mask
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // row_index [31:0], selected_so_far [63:32]
  output logic [btil_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser,  // found
  output logic                                out_tlast   // last_of_item
);
  import btil_pkg::*;

  logic         push_valid;
  logic         push_ready;
  btil_result_t push_data;
  btil_result_t out_data;

  btil_scan #(
    .ROW_INDEX_BITS(ROW_INDEX_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_tvalid),
    .load_ready (in_tready),
    .mask_word  (in_tdata[WORD_BITS-1:0]),
    .valid_bits (in_tdata[WORD_BITS +: VBITS_W]),
    .end_of_mask(in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  btil_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = {out_data.selected_so_far, out_data.row_index};
  assign out_tuser = out_data.found;
  assign out_tlast = out_data.last_of_item;

endmodule

FILE: rtl/btil_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btil_scan
// Bit-serial scanner: shifts the masked word out one bit per cycle, unless
// a set bit waits for the output side, and produces one result for each set
// bit, or one empty result for a word with no meaningful set bit.
// ----------------------------------------------------------------------------
module btil_scan #(
  parameter int ROW_INDEX_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load_valid,
  output logic                                 load_ready,
  input  logic [btil_pkg::WORD_BITS-1:0]       mask_word,
  input  logic [btil_pkg::VBITS_W-1:0]         valid_bits,
  input  logic                                 end_of_mask,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output btil_pkg::btil_result_t               push_data
);
  import btil_pkg::*;

  scan_state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0]      shift_r, shift_nxt;
  logic [ROW_INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [ROW_INDEX_BITS-1:0] base_r, base_nxt;
  logic [COUNT_W-1:0]        cnt_r, cnt_nxt;
  logic                      eom_r, eom_nxt;

  logic [WORD_BITS-1:0]      keep;
  logic [WORD_BITS-1:0]      masked;
  logic                      rest_zero;
  logic [COUNT_W-1:0]        cnt_inc;
  logic [OUT_ROW_W-1:0]      row_out;
  logic                      load;
  logic                      take_bit;

  // Thermometer of the meaningful bits; counts of 64 and above keep all.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      keep[i] = valid_bits[VBITS_W-1] || (VBITS_W'(i) < valid_bits);
    end
  end

  assign masked    = mask_word & keep;
  assign rest_zero = (shift_r[WORD_BITS-1:1] == '0);
  assign cnt_inc   = (cnt_r == '1) ? cnt_r : cnt_r + COUNT_W'(1);
  assign load      = load_valid && load_ready;
  assign take_bit  = push_valid && push_ready;

  generate
    if (ROW_INDEX_BITS >= OUT_ROW_W) begin : g_trunc
      assign row_out = idx_r[OUT_ROW_W-1:0];
    end else begin : g_ext
      assign row_out = {{(OUT_ROW_W-ROW_INDEX_BITS){1'b0}}, idx_r};
    end
  endgenerate

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (load_valid) begin
          state_nxt = (masked == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (shift_r[0] && rest_zero && push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    load_ready = 1'b0;
    push_valid = 1'b0;
    push_data  = '0;
    case (state_r)
      ST_IDLE: begin
        load_ready = 1'b1;
      end
      ST_EMPTY: begin
        push_valid                = 1'b1;
        push_data.selected_so_far = cnt_r;
        push_data.last_of_item    = 1'b1;
      end
      ST_SCAN: begin
        push_valid                = shift_r[0];
        push_data.row_index       = row_out;
        push_data.found           = 1'b1;
        push_data.selected_so_far = cnt_inc;
        push_data.last_of_item    = rest_zero;
      end
      default: begin
        load_ready = 1'b0;
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    shift_nxt = shift_r;
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    eom_nxt   = eom_r;
    if (load) begin
      shift_nxt = masked;
      idx_nxt   = base_r;
      eom_nxt   = end_of_mask;
      base_nxt  = end_of_mask ? '0 : base_r + ROW_INDEX_BITS'(WORD_BITS);
    end else if (state_r == ST_SCAN) begin
      // A clear bit moves on at once; a set bit waits for the output side.
      if (!shift_r[0] || push_ready) begin
        shift_nxt = shift_r >> 1;
        idx_nxt   = idx_r + ROW_INDEX_BITS'(1);
      end
      if (take_bit) begin
        cnt_nxt = (rest_zero && eom_r) ? '0 : cnt_inc;
      end
    end else if (state_r == ST_EMPTY && push_ready && eom_r) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      base_r  <= '0;
      cnt_r   <= '0;
      eom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      cnt_r   <= cnt_nxt;
      eom_r   <= eom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    idx_r   <= idx_nxt;
  end

endmodule

FILE: rtl/btil_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btil_obuf
// Output register that holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module btil_obuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  btil_pkg::btil_result_t push_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output btil_pkg::btil_result_t out_data
);
  import btil_pkg::*;

  logic         valid_r, valid_nxt;
  btil_result_t data_r;

  assign push_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push_ready) begin
      valid_nxt = push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      data_r <= push_data;
    end
  end

endmodule
